FILE: design/bhsm_pkg.sv
// Package: shared types, constants and fixed-point helpers for the skinning matrix block.
`default_nettype none
package bhsm_pkg;

  localparam int unsigned MaxBones = 64;
  localparam int unsigned FracBits = 16;
  localparam int unsigned BoneW    = 6;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned StoreAw  = BoneW + 4;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    MODE_OFFSET = 2'd0,
    MODE_SCALE  = 2'd1,
    MODE_ROT    = 2'd2,
    MODE_POSE   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [BoneW-1:0]  bone;
    logic              root;
    logic [BoneW-1:0]  parent;
    logic [1:0]        row;
    logic [ElemW-1:0]  vx;
    logic [ElemW-1:0]  vy;
    logic [ElemW-1:0]  vz;
    logic [ElemW-1:0]  vw;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUAT,
    ST_ROT,
    ST_LOCAL,
    ST_WRD,
    ST_WACC,
    ST_WST,
    ST_SRD,
    ST_SACC,
    ST_EMIT
  } state_e;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v, output logic f);
    f = 1'b0;
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      sat32 = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      f = 1'b1;
      sat32 = -64'sd2147483648;
    end else begin
      sat32 = v;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/bhsm_front.sv
// Front end: input acceptance and command queue.
`default_nettype none
module bhsm_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [144:0]         s_axis_tdata,
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i,
  output bhsm_pkg::cmd_t       cmd_o
);

  bhsm_pkg::cmd_t q_mem [bhsm_pkg::QDepth];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  bhsm_pkg::cmd_t c;
  logic           push, pop;

  always_comb begin
    c.mode   = bhsm_pkg::mode_e'(s_axis_tdata[1:0]);
    c.bone   = s_axis_tdata[7:2];
    c.root   = s_axis_tdata[14];
    c.parent = s_axis_tdata[13:8];
    c.row    = s_axis_tdata[16:15];
    c.vx     = s_axis_tdata[48:17];
    c.vy     = s_axis_tdata[80:49];
    c.vz     = s_axis_tdata[112:81];
    c.vw     = s_axis_tdata[144:113];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/bhsm_back.sv
// Back end: staged pose state, matrix engine with a single shared multiplier and result register.
`default_nettype none
module bhsm_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cmd_valid_i,
  output logic                 cmd_ready_o,
  input  bhsm_pkg::cmd_t       cmd_i,
  output logic                 m_valid_o,
  input  wire                  m_ready_i,
  output logic [5:0]           m_bone_o,
  output logic [1:0]           m_row_o,
  output logic [127:0]         m_cols_o,
  output logic                 m_last_o,
  output logic                 m_sat_o
);

  localparam logic signed [63:0] One  = 64'sd1 <<< bhsm_pkg::FracBits;
  localparam logic signed [63:0] Half = 64'sd1 <<< (bhsm_pkg::FracBits - 1);
  localparam logic signed [63:0] Qrt  = 64'sd1 <<< (bhsm_pkg::FracBits - 2);

  logic [127:0] off_mem [bhsm_pkg::MaxBones * 4];
  logic [31:0]  wld_mem [bhsm_pkg::MaxBones * 16];

  logic signed [31:0] sc_q [3];
  logic signed [31:0] rq_q [4];
  logic signed [63:0] qt_q [9];
  logic signed [31:0] loc_q [16];
  logic signed [31:0] wm_q [16];
  logic signed [63:0] acc_q;
  logic signed [31:0] res_q [16];

  bhsm_pkg::state_e st_q, st_d;
  bhsm_pkg::cmd_t   c_q;
  logic [3:0]  i_q, i_d;
  logic [2:0]  k_q, k_d;
  logic        flag_q;
  logic [31:0] rd_q;
  logic [bhsm_pkg::StoreAw-1:0] raddr;
  logic        rden;

  always_comb begin
    st_d = st_q;
    i_d  = i_q;
    k_d  = k_q;
    cmd_ready_o = 1'b0;
    rden  = 1'b0;
    raddr = '0;
    case (st_q)
      bhsm_pkg::ST_IDLE: begin
        cmd_ready_o = !m_valid_o;
        if (cmd_valid_i && !m_valid_o && cmd_i.mode == bhsm_pkg::MODE_POSE) begin
          st_d = bhsm_pkg::ST_QUAT;
          i_d  = '0;
        end
      end
      bhsm_pkg::ST_QUAT: begin
        i_d = i_q + 4'd1;
        if (i_q == 4'd8) begin
          st_d = bhsm_pkg::ST_ROT;
          i_d = '0;
        end
      end
      bhsm_pkg::ST_ROT: st_d = bhsm_pkg::ST_LOCAL;
      bhsm_pkg::ST_LOCAL: begin
        i_d = i_q + 4'd1;
        if (i_q == 4'd8) begin
          i_d = '0;
          k_d = '0;
          st_d = c_q.root ? bhsm_pkg::ST_WST : bhsm_pkg::ST_WRD;
        end
      end
      bhsm_pkg::ST_WRD, bhsm_pkg::ST_SRD: begin
        rden = 1'b1;
        if (st_q == bhsm_pkg::ST_WRD)
          raddr = {c_q.parent, k_q[1:0], i_q[1:0]};
        else
          raddr = {c_q.bone, i_q[3:2], k_q[1:0]};
        st_d = (st_q == bhsm_pkg::ST_WRD) ? bhsm_pkg::ST_WACC : bhsm_pkg::ST_SACC;
      end
      bhsm_pkg::ST_WACC, bhsm_pkg::ST_SACC: begin
        k_d = k_q + 3'd1;
        st_d = (st_q == bhsm_pkg::ST_WACC) ? bhsm_pkg::ST_WRD : bhsm_pkg::ST_SRD;
        if (k_q == 3'd4) begin
          k_d = '0;
          i_d = i_q + 4'd1;
          if (i_q == 4'd15) begin
            i_d = '0;
            st_d = (st_q == bhsm_pkg::ST_WACC) ? bhsm_pkg::ST_WST : bhsm_pkg::ST_EMIT;
          end
        end
      end
      bhsm_pkg::ST_WST: begin
        i_d = i_q + 4'd1;
        if (i_q == 4'd15) begin
          i_d = '0;
          k_d = '0;
          st_d = bhsm_pkg::ST_SRD;
        end
      end
      bhsm_pkg::ST_EMIT: begin
        if (m_valid_o && m_ready_i && m_row_o == 2'd3) st_d = bhsm_pkg::ST_IDLE;
      end
      default: st_d = bhsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rden) begin
      if (st_q == bhsm_pkg::ST_WRD) rd_q <= wld_mem[raddr];
      else rd_q <= off_mem[raddr[9:2]][{raddr[1:0], 5'd0} +: 32];
    end
    if (cmd_valid_i && cmd_ready_o && cmd_i.mode == bhsm_pkg::MODE_OFFSET)
      off_mem[{cmd_i.bone, cmd_i.row}] <= {cmd_i.vw, cmd_i.vz, cmd_i.vy, cmd_i.vx};
    if (st_q == bhsm_pkg::ST_WST)
      wld_mem[{c_q.bone, i_q}] <= c_q.root ? loc_q[i_q] : wm_q[i_q];
  end

  logic signed [63:0] p, pr, s, sv;
  logic               f;
  logic signed [31:0] ma, mb;
  logic [1:0]         pa, pb;
  logic [3:0]         ri;
  logic [1:0]         si;

  always_comb begin
    pa = 2'd0;
    pb = 2'd0;
    ri = 4'd0;
    si = 2'd0;
    case (i_q)
      4'd0: begin pa = 2'd0; pb = 2'd0; ri = 4'd0; si = 2'd0; end
      4'd1: begin pa = 2'd1; pb = 2'd1; ri = 4'd1; si = 2'd0; end
      4'd2: begin pa = 2'd2; pb = 2'd2; ri = 4'd2; si = 2'd0; end
      4'd3: begin pa = 2'd0; pb = 2'd1; ri = 4'd4; si = 2'd1; end
      4'd4: begin pa = 2'd0; pb = 2'd2; ri = 4'd5; si = 2'd1; end
      4'd5: begin pa = 2'd1; pb = 2'd2; ri = 4'd6; si = 2'd1; end
      4'd6: begin pa = 2'd0; pb = 2'd3; ri = 4'd8; si = 2'd2; end
      4'd7: begin pa = 2'd1; pb = 2'd3; ri = 4'd9; si = 2'd2; end
      default: begin pa = 2'd2; pb = 2'd3; ri = 4'd10; si = 2'd2; end
    endcase
    ma = '0;
    mb = '0;
    case (st_q)
      bhsm_pkg::ST_QUAT:  begin ma = rq_q[pa]; mb = rq_q[pb]; end
      bhsm_pkg::ST_LOCAL: begin ma = sc_q[si]; mb = loc_q[ri]; end
      bhsm_pkg::ST_WACC:  begin ma = loc_q[{i_q[3:2], k_q[1:0]}]; mb = rd_q; end
      bhsm_pkg::ST_SACC:  begin ma = rd_q; mb = wm_q[{k_q[1:0], i_q[1:0]}]; end
      default: ;
    endcase
    p  = ma * mb;
    pr = (st_q == bhsm_pkg::ST_QUAT) ? ((p + Qrt) >>> (bhsm_pkg::FracBits - 1))
                                     : ((p + Half) >>> bhsm_pkg::FracBits);
    s  = acc_q + pr;
    sv = bhsm_pkg::sat32(acc_q, f);
  end

  logic signed [63:0] rv [9];
  logic [8:0]         rf;
  always_comb begin
    rv[0] = bhsm_pkg::sat32(One - qt_q[1] - qt_q[2], rf[0]);
    rv[1] = bhsm_pkg::sat32(qt_q[3] + qt_q[8], rf[1]);
    rv[2] = bhsm_pkg::sat32(qt_q[4] - qt_q[7], rf[2]);
    rv[3] = bhsm_pkg::sat32(qt_q[3] - qt_q[8], rf[3]);
    rv[4] = bhsm_pkg::sat32(One - qt_q[0] - qt_q[2], rf[4]);
    rv[5] = bhsm_pkg::sat32(qt_q[5] + qt_q[6], rf[5]);
    rv[6] = bhsm_pkg::sat32(qt_q[4] + qt_q[7], rf[6]);
    rv[7] = bhsm_pkg::sat32(qt_q[5] - qt_q[6], rf[7]);
    rv[8] = bhsm_pkg::sat32(One - qt_q[0] - qt_q[1], rf[8]);
  end

  logic signed [63:0] lv;
  logic               lf;
  always_comb lv = bhsm_pkg::sat32(pr, lf);

  always_ff @(posedge clk_i) begin
    case (st_q)
      bhsm_pkg::ST_IDLE: begin
        c_q <= cmd_i;
        if (cmd_valid_i && cmd_ready_o && cmd_i.mode == bhsm_pkg::MODE_POSE) begin
          loc_q[3]  <= '0;
          loc_q[7]  <= '0;
          loc_q[11] <= '0;
          loc_q[12] <= cmd_i.vx;
          loc_q[13] <= cmd_i.vy;
          loc_q[14] <= cmd_i.vz;
          loc_q[15] <= 32'(One);
        end
      end
      bhsm_pkg::ST_QUAT: qt_q[i_q] <= pr;
      bhsm_pkg::ST_ROT: begin
        for (int n = 0; n < 9; n++) loc_q[(n / 3) * 4 + (n % 3)] <= rv[n][31:0];
      end
      bhsm_pkg::ST_LOCAL: loc_q[ri] <= lv[31:0];
      bhsm_pkg::ST_WRD, bhsm_pkg::ST_SRD: if (k_q == 3'd0) acc_q <= '0;
      bhsm_pkg::ST_WACC, bhsm_pkg::ST_SACC: begin
        if (k_q == 3'd4) begin
          if (st_q == bhsm_pkg::ST_WACC) wm_q[i_q] <= sv[31:0];
          else res_q[i_q] <= sv[31:0];
          acc_q <= '0;
        end else begin
          acc_q <= s;
        end
      end
      bhsm_pkg::ST_WST: if (c_q.root) wm_q[i_q] <= loc_q[i_q];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= bhsm_pkg::ST_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      flag_q   <= 1'b0;
      m_valid_o <= 1'b0;
      m_row_o  <= '0;
      sc_q[0]  <= 32'(One);
      sc_q[1]  <= 32'(One);
      sc_q[2]  <= 32'(One);
      rq_q[0]  <= '0;
      rq_q[1]  <= '0;
      rq_q[2]  <= '0;
      rq_q[3]  <= 32'(One);
    end else begin
      st_q <= st_d;
      i_q  <= i_d;
      k_q  <= k_d;
      if (cmd_valid_i && cmd_ready_o) begin
        if (cmd_i.mode == bhsm_pkg::MODE_SCALE) begin
          sc_q[0] <= cmd_i.vx;
          sc_q[1] <= cmd_i.vy;
          sc_q[2] <= cmd_i.vz;
        end
        if (cmd_i.mode == bhsm_pkg::MODE_ROT) begin
          rq_q[0] <= cmd_i.vx;
          rq_q[1] <= cmd_i.vy;
          rq_q[2] <= cmd_i.vz;
          rq_q[3] <= cmd_i.vw;
        end
        flag_q <= 1'b0;
      end
      if (st_q == bhsm_pkg::ST_ROT && (|rf)) flag_q <= 1'b1;
      if (st_q == bhsm_pkg::ST_LOCAL && lf) flag_q <= 1'b1;
      if ((st_q == bhsm_pkg::ST_WACC || st_q == bhsm_pkg::ST_SACC) && k_q == 3'd4 && f)
        flag_q <= 1'b1;
      if (st_q == bhsm_pkg::ST_SACC && k_q == 3'd4 && i_q == 4'd15) begin
        m_valid_o <= 1'b1;
        m_row_o   <= 2'd0;
      end else if (m_valid_o && m_ready_i) begin
        if (m_row_o == 2'd3) m_valid_o <= 1'b0;
        else m_row_o <= m_row_o + 2'd1;
      end
    end
  end

  assign m_bone_o = c_q.bone;
  assign m_last_o = (m_row_o == 2'd3);
  assign m_sat_o  = flag_q;
  assign m_cols_o = {res_q[{m_row_o, 2'd3}], res_q[{m_row_o, 2'd2}],
                     res_q[{m_row_o, 2'd1}], res_q[{m_row_o, 2'd0}]};

endmodule
`default_nettype wire

FILE: design/bone_hierarchy_skinning_matrices_top.sv
// Top level of the skinning matrix palette block.
// Input stream s_axis: one transaction per item; tdata fields from bit 0:
// mode[1:0], bone_index[7:2], parent_index[13:8], root[14], row_select[16:15],
// value_x, value_y, value_z, value_w (32 bits each from bit 17).
// Output stream m_axis: four transactions per pose item, tlast on row 3;
// tdata: out_bone, out_row, col0..col3; tuser: saturated.
// A two-entry queue separates acceptance from the engine. Modes 0 to 2 are
// handled in the engine's idle state. A pose runs nine quaternion products,
// a rotation step and nine scale products, then two 4x4 products, each
// element taking four reads and accumulates and one saturate, through one
// store port; a root skips the parent product. Rows then follow one per
// cycle while the receiver accepts them, and the engine takes the next
// item only after the last row is accepted.
// Reset clears the queue and the engine state and sets the staged scale
// and rotation to identity; bone stores stay undefined until written. A
// receiver stall holds the current row and the engine waits.
`default_nettype none
module bone_hierarchy_skinning_matrices_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [151:0] s_axis_tdata,  // mode, bone_index, parent_index, row_select, value_x..w
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [135:0] m_axis_tdata,  // out_bone, out_row, col0, col1, col2, col3
  output logic         m_axis_tlast,
  output logic         m_axis_tuser   // saturated
);

  logic           cv, cr;
  bhsm_pkg::cmd_t cmd;
  logic [5:0]     ob;
  logic [1:0]     orow;
  logic [127:0]   cols;

  bhsm_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata[144:0]),
    .cmd_valid_o   (cv),
    .cmd_ready_i   (cr),
    .cmd_o         (cmd)
  );

  bhsm_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cv),
    .cmd_ready_o (cr),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_bone_o    (ob),
    .m_row_o     (orow),
    .m_cols_o    (cols),
    .m_last_o    (m_axis_tlast),
    .m_sat_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {cols, orow, ob};

`ifndef SYNTHESIS
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser)) else $error("output changed while stalled");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
`endif

endmodule
`default_nettype wire
